@@ hdl/dcc_pkg.sv @@
// Shared types and constants of the directory coherence controller.
package dcc_pkg;

  localparam logic [1:0] ST_INV = 2'd0;
  localparam logic [1:0] ST_SHR = 2'd1;
  localparam logic [1:0] ST_EXC = 2'd2;

  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_BAD_CPU = 2'd1;
  localparam logic [1:0] STS_BAD_BLK = 2'd2;

  localparam logic [1:0] REG_CPUS   = 2'd0;
  localparam logic [1:0] REG_LINES  = 2'd1;
  localparam logic [1:0] REG_BLOCKS = 2'd2;

  localparam int CPU_W   = 4;
  localparam int BLK_W   = 7;
  localparam int SHR_W   = 16;
  localparam int CFG_W   = 8;

  // result word fields
  typedef struct packed {
    logic [BLK_W-1:0] evicted_block;
    logic             evicted;
    logic [SHR_W-1:0] sharers;
    logic [1:0]       directory_state;
    logic [1:0]       line_state;
    logic             hit;
    logic [1:0]       status;
  } result_t;

endpackage

@@ hdl/dcc_ram.sv @@
// Generic single-port RAM with registered read.
module dcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ hdl/dcc_mod.sv @@
// Iterative remainder unit: block mod lines, one subtract-compare per cycle.
module dcc_mod #(
  parameter int VW = 7,
  parameter int DW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [VW-1:0] value,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [VW-1:0] rem
);
  localparam int CW = $clog2(VW + 1);
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [VW:0]   trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, q_r[VW-1]};
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = value;
      cnt_nxt  = CW'(VW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = {q_r[VW-2:0], 1'b0};
      if (trial >= (VW+1)'(divisor)) rem_nxt = VW'(trial - (VW+1)'(divisor));
      else rem_nxt = trial[VW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done = busy_r && (cnt_r == CW'(1));
  assign rem  = rem_nxt;
endmodule

@@ hdl/directory_coherence_controller.sv @@
// Directory coherence controller (MSI) for up to MAX_CPUS private direct-mapped caches.
// One request word is handled at a time: in_tready is low from acceptance until the result
// word has been taken, and rises the cycle after that handshake. out_tvalid rises once the
// line index (block mod lines) has come from a bit-serial remainder unit and the requester
// line and the directory entry have been read and written through single-port memories.
// Evicting a different valid block adds a read and a write-back of its directory entry. When
// a write takes ownership, or a read misses on an exclusive block, and other sharer bits are
// set, a sequencer walks all MAX_CPUS sharer bits, with a read state for every bit and a
// write state added for each set bit. An out-of-range CPU or block goes straight to the
// result. After reset the line-state memory (MAX_CPUS*MAX_LINES entries) and the directory
// (MAX_BLOCKS entries) are cleared in one joint pass before in_tready rises.
module directory_coherence_controller #(
  parameter int MAX_CPUS   = 16,
  parameter int MAX_LINES  = 16,
  parameter int MAX_BLOCKS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // action[0], cpu[4:1], block[11:5]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // status[1:0], hit[2], line_state[4:3],
                                  // directory_state[6:5], sharers[22:7],
                                  // evicted[23], evicted_block[30:24]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  localparam int CW  = $clog2(MAX_CPUS);
  localparam int LW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int BW  = $clog2(MAX_BLOCKS);
  localparam int NL  = MAX_CPUS * MAX_LINES;
  localparam int PW  = $clog2(NL);
  localparam int CLRW = (PW > BW ? PW : BW) + 1;
  localparam int BLK_W = dcc_pkg::BLK_W;
  localparam int SHR_W = dcc_pkg::SHR_W;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_RDL   = 4'd3;
  localparam logic [3:0] S_LINE  = 4'd4;
  localparam logic [3:0] S_RDO   = 4'd5;
  localparam logic [3:0] S_EVW   = 4'd6;
  localparam logic [3:0] S_RDN   = 4'd7;
  localparam logic [3:0] S_NEW   = 4'd8;
  localparam logic [3:0] S_WRD   = 4'd9;
  localparam logic [3:0] S_WALKR = 4'd10;
  localparam logic [3:0] S_WALKW = 4'd11;
  localparam logic [3:0] S_WRL   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] st_r, st_nxt;
  logic [4:0] ncpu_r;
  logic [4:0] nlin_r;
  logic [dcc_pkg::CFG_W-1:0] nblk_r;

  logic             wr_r;
  logic [CW-1:0]    cpu_r;
  logic [BLK_W-1:0] blk_r;
  logic [LW-1:0]    idx_r;
  logic [1:0]       ls_r;
  logic [BLK_W-1:0] old_r;
  logic             hit_r;
  logic             ev_r;
  logic [1:0]       nls_r;
  logic [1:0]       dst_r;
  logic [MAX_CPUS-1:0] dsh_r;
  logic [MAX_CPUS-1:0] walk_sh_r;
  logic             walk_inv_r;
  logic [CW:0]      wc_r;
  logic [CLRW-1:0]  clr_r;
  dcc_pkg::result_t res_r;
  logic             ovalid_r;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncpu_r <= 5'd16;
      nlin_r <= 5'd16;
      nblk_r <= 8'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dcc_pkg::REG_CPUS:   ncpu_r <= cfg_wdata[4:0];
        dcc_pkg::REG_LINES:  nlin_r <= cfg_wdata[4:0];
        dcc_pkg::REG_BLOCKS: nblk_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective limits
  logic [7:0] ecpu, elin, eblk;
  always_comb begin
    ecpu = (32'(ncpu_r) > MAX_CPUS)   ? 8'(MAX_CPUS)  : 8'(ncpu_r);
    eblk = (32'(nblk_r) > MAX_BLOCKS) ? 8'(MAX_BLOCKS) : nblk_r;
    elin = (32'(nlin_r) > MAX_LINES)  ? 8'(MAX_LINES) : 8'(nlin_r);
    if (elin == 8'd0) elin = 8'd1;
  end

  logic                      in_wr;
  logic [dcc_pkg::CPU_W-1:0] in_cpu;
  logic [BLK_W-1:0]          in_blk;
  assign in_wr  = in_tdata[0];
  assign in_cpu = in_tdata[4:1];
  assign in_blk = in_tdata[11:5];
  logic acc;
  assign acc = in_tvalid && in_tready;
  assign in_tready = (st_r == S_IDLE) && !ovalid_r;

  // cpu is checked before block
  logic [1:0] in_sts;
  always_comb begin
    priority if ({4'd0, in_cpu} >= ecpu) in_sts = dcc_pkg::STS_BAD_CPU;
    else if ({1'b0, in_blk} >= eblk) in_sts = dcc_pkg::STS_BAD_BLK;
    else in_sts = dcc_pkg::STS_DONE;
  end

  // remainder unit
  logic mod_start, mod_done;
  logic [BLK_W-1:0] mod_rem;
  dcc_mod #(.VW(BLK_W), .DW(5)) u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .value(in_blk),
    .divisor(elin[4:0]), .done(mod_done), .rem(mod_rem)
  );

  // memories: line state, line tag, directory (state + sharers)
  logic          ls_we;   logic [PW-1:0] ls_a;  logic [1:0] ls_wd, ls_rd;
  logic          tg_we;   logic [BLK_W-1:0] tg_rd;
  logic          dr_we;   logic [BW-1:0] dr_a;
  logic [MAX_CPUS+1:0] dr_wd, dr_rd;

  dcc_ram #(.WIDTH(2), .DEPTH(NL)) u_ls (
    .clk(clk), .we(ls_we), .addr(ls_a), .wdata(ls_wd), .rdata(ls_rd));
  dcc_ram #(.WIDTH(BLK_W), .DEPTH(NL)) u_tag (
    .clk(clk), .we(tg_we), .addr(ls_a), .wdata(blk_r), .rdata(tg_rd));
  dcc_ram #(.WIDTH(MAX_CPUS+2), .DEPTH(MAX_BLOCKS)) u_dir (
    .clk(clk), .we(dr_we), .addr(dr_a), .wdata(dr_wd), .rdata(dr_rd));

  // line address: cpu * MAX_LINES + index
  logic [PW-1:0] req_pos, walk_pos;
  assign req_pos  = PW'(cpu_r) * PW'(MAX_LINES) + PW'(idx_r);
  assign walk_pos = PW'(wc_r[CW-1:0]) * PW'(MAX_LINES) + PW'(idx_r);

  logic [MAX_CPUS-1:0] req_bit;
  assign req_bit = MAX_CPUS'(1) << cpu_r;

  logic [MAX_CPUS-1:0] old_sh_after;
  assign old_sh_after = dr_rd[MAX_CPUS-1:0] & ~req_bit;

  always_comb begin
    st_nxt = st_r;
    mod_start = 1'b0;
    ls_we = 1'b0; ls_a = req_pos; ls_wd = nls_r;
    tg_we = 1'b0;
    dr_we = 1'b0; dr_a = BW'(blk_r); dr_wd = {dst_r, dsh_r};
    unique case (st_r)
      S_CLR: begin
        ls_we = (32'(clr_r) < NL);
        ls_a  = clr_r[PW-1:0];
        ls_wd = dcc_pkg::ST_INV;
        dr_we = (32'(clr_r) < MAX_BLOCKS);
        dr_a  = clr_r[BW-1:0];
        dr_wd = '0;
        if (32'(clr_r) >= NL - 1 && 32'(clr_r) >= MAX_BLOCKS - 1) st_nxt = S_IDLE;
      end
      S_IDLE: if (acc) begin
        if (in_sts != dcc_pkg::STS_DONE) st_nxt = S_OUT;
        else begin
          mod_start = 1'b1;
          st_nxt = S_MOD;
        end
      end
      S_MOD:   if (mod_done) st_nxt = S_RDL;
      S_RDL:   st_nxt = S_LINE;
      S_LINE: begin
        dr_a = BW'(tg_rd);
        if (ls_rd != dcc_pkg::ST_INV && tg_rd != blk_r) st_nxt = S_RDO;
        else st_nxt = S_RDN;
      end
      S_RDO: begin
        dr_a = BW'(old_r);
        st_nxt = S_EVW;
      end
      S_EVW: begin
        dr_a  = BW'(old_r);
        dr_we = 1'b1;
        // shared eviction keeps the directory state while other sharers remain
        if (ls_r == dcc_pkg::ST_EXC || old_sh_after == '0) dr_wd = '0;
        else dr_wd = {dr_rd[MAX_CPUS+1:MAX_CPUS], old_sh_after};
        st_nxt = S_RDN;
      end
      S_RDN: st_nxt = S_NEW;
      S_NEW: st_nxt = S_WRD;
      S_WRD: begin
        dr_we = 1'b1;
        st_nxt = (walk_sh_r != '0) ? S_WALKR : S_WRL;
      end
      S_WALKR: begin
        ls_a = walk_pos;
        if (!walk_sh_r[wc_r[CW-1:0]]) begin
          if (32'(wc_r) == MAX_CPUS - 1) st_nxt = S_WRL;
        end else st_nxt = S_WALKW;
      end
      S_WALKW: begin
        ls_a  = walk_pos;
        ls_we = walk_inv_r || (ls_rd == dcc_pkg::ST_EXC);
        ls_wd = walk_inv_r ? dcc_pkg::ST_INV : dcc_pkg::ST_SHR;
        st_nxt = (32'(wc_r) == MAX_CPUS - 1) ? S_WRL : S_WALKR;
      end
      S_WRL: begin
        ls_we = 1'b1;
        tg_we = 1'b1;
        st_nxt = S_OUT;
      end
      S_OUT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_CLR;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
      wc_r     <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (out_tvalid && out_tready) ovalid_r <= 1'b0;
      else if (st_r == S_OUT) ovalid_r <= 1'b1;
      if (st_r == S_WRD) wc_r <= '0;
      else if ((st_r == S_WALKR && !walk_sh_r[wc_r[CW-1:0]]) || st_r == S_WALKW)
        wc_r <= wc_r + 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: if (acc) begin
        wr_r  <= in_wr;
        cpu_r <= CW'(in_cpu);
        blk_r <= in_blk;
        res_r <= dcc_pkg::result_t'({29'd0, in_sts});
      end
      S_MOD: if (mod_done) idx_r <= LW'(mod_rem);
      S_LINE: begin
        ls_r  <= ls_rd;
        old_r <= tg_rd;
        hit_r <= (ls_rd != dcc_pkg::ST_INV) && (tg_rd == blk_r);
        ev_r  <= (ls_rd != dcc_pkg::ST_INV) && (tg_rd != blk_r);
      end
      S_NEW: begin
        walk_inv_r <= wr_r;
        if (wr_r && !(hit_r && ls_r == dcc_pkg::ST_EXC)) begin
          nls_r <= dcc_pkg::ST_EXC;
          dst_r <= dcc_pkg::ST_EXC;
          dsh_r <= req_bit;
          walk_sh_r <= dr_rd[MAX_CPUS-1:0] & ~req_bit;
        end else if (!wr_r && !hit_r) begin
          nls_r <= dcc_pkg::ST_SHR;
          dst_r <= dcc_pkg::ST_SHR;
          dsh_r <= dr_rd[MAX_CPUS-1:0] | req_bit;
          walk_sh_r <= (dr_rd[MAX_CPUS+1:MAX_CPUS] == dcc_pkg::ST_EXC) ?
                       (dr_rd[MAX_CPUS-1:0] & ~req_bit) : '0;
        end else begin
          nls_r <= ls_r;
          dst_r <= dr_rd[MAX_CPUS+1:MAX_CPUS];
          dsh_r <= dr_rd[MAX_CPUS-1:0];
          walk_sh_r <= '0;
        end
      end
      S_WRL: begin
        res_r <= {(ev_r ? old_r : BLK_W'(0)), ev_r, SHR_W'(dsh_r), dst_r, nls_r, hit_r,
                  res_r.status};
      end
      default: ;
    endcase
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {1'b0, res_r};
endmodule
